/* hw/rtl/modexp_pkg.sv */
// Package with shared types and register indexes for the modular exponentiation block.
package modexp_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_STEP   = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

endpackage

/* hw/rtl/modexp_if.sv */
// Valid/ready channel interface carrying one payload per request.
interface modexp_if #(
   parameter int unsigned WIDTH = 64
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   logic             flag;

   modport source (output valid, output data, output flag, input ready);
   modport sink (input valid, input data, input flag, output ready);
endinterface

/* hw/rtl/modexp_cell.sv */
// One bit cell of the interleaved modular multiplier row.
module modexp_cell (
   input  logic clock,
   input  logic load,
   input  logic enable,
   input  logic r_bit,
   input  logic a_bit,
   input  logic m_bit,
   input  logic sel_add,
   input  logic carry_in,
   input  logic borrow_in,
   output logic carry_out,
   output logic borrow_out,
   output logic sum_bit,
   output logic diff_bit,
   output logic b_bit,
   input  logic b_load_bit,
   input  logic b_shift_in
);
   // A cell holds one bit of the multiplier operand b, shifted toward the MSB
   // each step, and forms one bit of the sum and the trial difference.
   logic b_ff;
   logic b_in;
   logic addend;

   always_comb begin
      addend     = sel_add & a_bit;
      sum_bit    = r_bit ^ addend ^ carry_in;
      carry_out  = (r_bit & addend) | (carry_in & (r_bit ^ addend));
      diff_bit   = sum_bit ^ m_bit ^ borrow_in;
      borrow_out = (~sum_bit & m_bit) | (borrow_in & ~(sum_bit ^ m_bit));
      b_in       = b_ff;
      if (load) begin
         b_in = b_load_bit;
      end else if (enable) begin
         b_in = b_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
   end

   assign b_bit = b_ff;
endmodule

/* hw/rtl/modexp_mulmod.sv */
// Bit-serial modular multiplier built from a row of bit cells.
module modexp_mulmod #(
   parameter int unsigned WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] a_value,
   input  logic [WIDTH-1:0] b_value,
   input  logic [WIDTH-1:0] m_value,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] product
);
   localparam int unsigned CW = $clog2(WIDTH + 1);
   localparam int unsigned XW = WIDTH + 2;

   // r < m; each step r = 2r (+a) reduced with up to two subtractions of m.
   // Phase 0 doubles, phase 1 adds a; each phase subtracts m once if needed.
   logic [XW-1:0]   r_ff, r_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            phase_ff, phase_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [WIDTH-1:0] b_bits;
   logic [XW-1:0]   r_src;
   logic [XW-1:0]   a_src;
   logic [XW-1:0]   m_ext;
   logic [XW:0]     carry;
   logic [XW:0]     borrow;
   logic [XW-1:0]   sum;
   logic [XW-1:0]   diff;
   logic            add_now;

   assign m_ext   = {2'b00, m_value};
   assign r_src   = r_ff;
   assign add_now = phase_ff ? b_bits[WIDTH-1] : 1'b1;
   assign a_src   = phase_ff ? {2'b00, a_value} : r_ff;
   assign carry[0]  = 1'b0;
   assign borrow[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < XW; g++) begin : g_cell
         if (g < WIDTH) begin : g_b
            logic shift_in;
            if (g == 0) begin : g_lsb
               assign shift_in = 1'b0;
            end else begin : g_mid
               assign shift_in = b_bits[g-1];
            end
            modexp_cell u_cell (
               .clock      (clock),
               .load       (start),
               .enable     (busy_ff & phase_ff),
               .r_bit      (r_src[g]),
               .a_bit      (a_src[g]),
               .m_bit      (m_ext[g]),
               .sel_add    (add_now),
               .carry_in   (carry[g]),
               .borrow_in  (borrow[g]),
               .carry_out  (carry[g+1]),
               .borrow_out (borrow[g+1]),
               .sum_bit    (sum[g]),
               .diff_bit   (diff[g]),
               .b_bit      (b_bits[g]),
               .b_load_bit (b_value[g]),
               .b_shift_in (shift_in)
            );
         end else begin : g_top
            logic b_unused;
            modexp_cell u_cell (
               .clock      (clock),
               .load       (1'b0),
               .enable     (1'b0),
               .r_bit      (r_src[g]),
               .a_bit      (a_src[g]),
               .m_bit      (m_ext[g]),
               .sel_add    (add_now),
               .carry_in   (carry[g]),
               .borrow_in  (borrow[g]),
               .carry_out  (carry[g+1]),
               .borrow_out (borrow[g+1]),
               .sum_bit    (sum[g]),
               .diff_bit   (diff[g]),
               .b_bit      (b_unused),
               .b_load_bit (1'b0),
               .b_shift_in (1'b0)
            );
         end
      end
   endgenerate

   always_comb begin
      r_in     = r_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         r_in     = '0;
         count_in = CW'(WIDTH);
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // Sum stays below 2m, so one conditional subtraction restores r < m.
         r_in     = borrow[XW] ? sum : diff;
         phase_in = ~phase_ff;
         if (phase_ff) begin
            count_in = count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      r_ff <= r_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = r_ff[WIDTH-1:0];
endmodule

/* hw/rtl/modexp_reduce.sv */
// Restoring reduction of one operand modulo m, one quotient bit per cycle.
module modexp_reduce #(
   parameter int unsigned WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] value,
   input  logic [WIDTH-1:0] m_value,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);
   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] trial;

   always_comb begin
      shifted  = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      trial    = {1'b0, shifted} - {2'b00, m_value};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = value;
         count_in = CW'(WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = trial[WIDTH+1] ? shifted : trial[WIDTH:0];
         quo_in   = {quo_ff[WIDTH-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[WIDTH-1:0];
endmodule

/* hw/rtl/modular_exponentiation.sv */
// Top level of the right-to-left binary modular exponentiation block.
//
//   channel   direction  handshake      payload
//   req       in         valid/ready    message
//   rsp       out        valid/ready    power_result, modulus_error
//   csr       in         write enable   index, data (exponent, modulus)
//
// One request first reduces the message, then runs a squaring for every
// exponent bit below the highest set one, and a multiply for every set
// bit, each in the shared bit-serial multiplier; the multiplier's cell
// row sets the pace.
// A zero modulus or zero exponent skips the reduction and the multiplies;
// the next request can be taken in the cycle its response is offered.
// Reset is synchronous and clears the csr registers and the control state.
// A waiting response sits in its own output register; the next request is
// taken and worked on, and only its finish waits for rsp ready.
module modular_exponentiation #(
   parameter int unsigned OPERAND_WIDTH = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   modexp_if.sink                                   req,
   modexp_if.source                                 rsp,
   input  logic                                     csr_write_enable,
   input  logic [modexp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [OPERAND_WIDTH-1:0]                 csr_write_data
);
   import modexp_pkg::*;

   localparam int unsigned W = OPERAND_WIDTH;

   // The csr index port is one bit wide, so every index maps to a register;
   // index 0 holds the exponent and index 1 the modulus.
   logic [W-1:0] exponent_ff, exponent_in;
   logic [W-1:0] modulus_ff, modulus_in;

   state_type    state_ff, state_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] ebits_ff, ebits_in;
   logic         mul_sq_ff, mul_sq_in;   // current multiply is the squaring
   logic         error_ff, error_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_data_ff, rsp_data_in;
   logic         rsp_flag_ff, rsp_flag_in;

   logic         red_start;
   logic         red_done;
   logic [W-1:0] red_value;
   logic         mul_start;
   logic         mul_busy;
   logic         mul_done;
   logic [W-1:0] mul_a;
   logic [W-1:0] mul_b;
   logic [W-1:0] mul_p;

   modexp_reduce #(.WIDTH(W)) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (req.data),
      .m_value   (modulus_ff),
      .done      (red_done),
      .remainder (red_value)
   );

   modexp_mulmod #(.WIDTH(W)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_value (mul_a),
      .b_value (mul_b),
      .m_value (modulus_ff),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_p)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign red_start = req.valid && req.ready && (modulus_ff != '0)
                      && (exponent_ff != '0);

   // The accumulator multiply comes first for a set bit, then the squaring.
   // The multiplier loads b at its start, so b is taken from the values that
   // the step registers at that edge; a is read later from the base register.
   assign mul_a = base_ff;
   assign mul_b = mul_sq_in ? base_in : acc_in;

   always_comb begin
      exponent_in  = exponent_ff;
      modulus_in   = modulus_ff;
      state_in     = state_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      ebits_in     = ebits_ff;
      mul_sq_in    = mul_sq_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;
      mul_start    = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPONENT: exponent_in = csr_write_data;
            CSR_MODULUS:  modulus_in  = csr_write_data;
            default:      ;
         endcase
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               acc_in   = W'(1);
               ebits_in = exponent_ff;
               error_in = 1'b0;
               if (modulus_ff == '0) begin
                  acc_in   = '0;
                  error_in = 1'b1;
                  state_in = ST_DONE;
               end else if (exponent_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (red_done) begin
               base_in   = red_value;
               mul_sq_in = ~ebits_ff[0];
               mul_start = 1'b1;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            if (mul_done) begin
               if (!mul_sq_ff) begin
                  acc_in    = mul_p;
                  mul_sq_in = 1'b1;
                  if (ebits_ff[W-1:1] == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     mul_start = 1'b1;
                  end
               end else begin
                  base_in   = mul_p;
                  ebits_in  = ebits_ff >> 1;
                  mul_sq_in = ~ebits_ff[1];
                  mul_start = 1'b1;
               end
            end
         end
         ST_DONE: begin
            // The finished result moves to the output register once it is
            // free, which includes the edge at which the old one is taken.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               rsp_flag_in  = error_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff  <= '0;
         modulus_ff   <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      ebits_ff    <= ebits_in;
      mul_sq_ff   <= mul_sq_in;
      error_ff    <= error_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
   assign rsp.flag  = rsp_flag_ff;

`ifndef SYNTHESIS
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("request taken while a request is in progress");
   a_mul_only_in_step: assert property (@(posedge clock) disable iff (reset)
      mul_busy |-> (state_ff == ST_STEP))
      else $error("multiplier running outside the step state");
   a_error_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.flag) |-> (rsp.data == '0))
      else $error("modulus error with a nonzero result");
`endif
endmodule

/* sim/tb.sv */
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module tb;
   import modexp_pkg::*;

   localparam int unsigned W = 64;
   // Cycles without any accepted request or response before the run is abandoned.
   // The slowest request uses a full exponent, and the long receiver hold-off
   // adds to that.
   localparam int unsigned IDLE_LIMIT = 100000;
   localparam int unsigned RANDOM_REQUESTS = 600;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [W-1:0] power;
      logic         error;
   } power_expect_type;

   // Scoreboard: keeps its own copy of the two registers, predicts the result
   // of every accepted request and compares responses in order.
   class power_scoreboard;
      logic [W-1:0]     exponent_value;
      logic [W-1:0]     modulus_value;
      power_expect_type pending[$];
      int               error_count;

      function new();
         exponent_value = '0;
         modulus_value  = '0;
         error_count    = 0;
      endfunction

      function logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
         logic [2*W-1:0] prod;
         prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
         prod = prod % {{W{1'b0}}, m};
         return prod[W-1:0];
      endfunction

      function power_expect_type predict_power(logic [W-1:0] message);
         power_expect_type res;
         logic [W-1:0]     acc;
         logic [W-1:0]     base;
         logic [W-1:0]     e;
         if (modulus_value == '0) begin
            res.power = '0;
            res.error = 1'b1;
            return res;
         end
         acc  = W'(1);
         base = message;
         e    = exponent_value;
         while (e != '0) begin
            if (e[0]) acc = mul_mod(acc, base, modulus_value);
            e    = e >> 1;
            base = mul_mod(base, base, modulus_value);
         end
         res.power = acc;
         res.error = 1'b0;
         return res;
      endfunction

      function void note_request(logic [W-1:0] message);
         pending.push_back(predict_power(message));
      endfunction

      task report(string text);
         $display("mismatch: %s", text);
         error_count++;
      endtask

      task check_response(logic [W-1:0] power, logic error);
         power_expect_type exp_res;
         if (pending.size() == 0) begin
            report($sformatf("response %h/%b with nothing outstanding", power, error));
         end else begin
            exp_res = pending.pop_front();
            if (power !== exp_res.power)
               report($sformatf("power_result %h, predicted %h", power, exp_res.power));
            if (error !== exp_res.error)
               report($sformatf("modulus_error %b, predicted %b", error, exp_res.error));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [W-1:0] csr_write_data;

   modexp_if #(.WIDTH(W)) req_ch ();
   modexp_if #(.WIDTH(W)) rsp_ch ();

   modular_exponentiation #(.OPERAND_WIDTH(W)) dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   power_scoreboard sb = new();

   // When quiet is set neither side inserts random gaps, so back-to-back
   // traffic is covered as well as gaps on every phase of the work.
   bit quiet;
   int unsigned response_count;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // All inputs are known from time zero; reset is asserted once, from the start.
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_EXPONENT;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.data      = '0;
      req_ch.flag      = 1'b0;
      rsp_ch.ready     = 1'b0;
   end

   function automatic logic [W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Drives one register write until the next falling edge and mirrors it in the scoreboard.
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [W-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == CSR_EXPONENT) sb.exponent_value = value;
      else                       sb.modulus_value  = value;
   endtask

   // Registers change only once every outstanding request has been answered.
   task automatic configure(logic [W-1:0] exponent, logic [W-1:0] modulus);
      if (req_ch.valid) begin
         req_ch.valid = 1'b0;
      end
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_csr(CSR_EXPONENT, exponent);
      write_csr(CSR_MODULUS, modulus);
   endtask

   // Offers one request after a random gap and returns at the falling edge
   // after it was accepted. Valid stays high into the next request if no gap is drawn.
   task automatic send_request(logic [W-1:0] message);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data  = message;
      req_ch.flag  = 1'($urandom_range(0, 1));
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(message);
      @(negedge clock);
   endtask

   // Response side: random ready gaps, and one long hold-off while the sender
   // keeps offering requests so the block backs up and stalls its input.
   initial begin
      int unsigned gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (response_count == 30) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
               rsp_ch.ready = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         sb.check_response(rsp_ch.data, rsp_ch.flag);
         response_count++;
         @(negedge clock);
      end
   end

   // Watchdog: counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      logic [W-1:0] exponent;
      logic [W-1:0] modulus;
      logic [W-1:0] message;
      int unsigned  bits;
      int unsigned  count;
      int unsigned  pick;
      int unsigned  random_sent;
      response_count = 0;
      quiet          = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part. Registers at their reset values give a zero modulus.
      send_request('0);
      send_request('1);
      // Zero modulus flags an error whatever the exponent is.
      configure('1, '0);
      send_request(rand64());
      // Zero exponent answers 1 without reduction, even for a modulus of one.
      configure('0, W'(1));
      send_request(W'(5));
      configure('0, '1);
      send_request('1);
      // A message at or above the modulus is reduced before the first multiply.
      configure(W'(1), '1);
      send_request('1);
      send_request('1 - 1);
      configure(W'(2), W'(1));
      send_request(W'(7));
      // Full-width exponent and modulus.
      configure('1, '1);
      send_request(W'(2));
      send_request('1 - 1);
      // Textbook key pair sized values.
      configure(W'(65537), W'(3233));
      send_request('0);
      send_request(W'(1));
      send_request(W'(65));
      send_request(W'(3232));
      send_request(W'(3233));
      send_request('1);
      configure(rand64() >> 56, W'(2));
      send_request(rand64());
      send_request(rand64());

      // Random part. Most phases use short exponents to keep the run bounded;
      // a few use the full width with only a handful of requests.
      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) bits = $urandom_range(1, 8);
         else if (pick < 95) bits = $urandom_range(9, 20);
         else bits = W;
         exponent = (rand64() >> (W - bits)) | (64'd1 << (bits - 1));
         if ($urandom_range(0, 19) == 0) exponent = '0;
         pick = $urandom_range(0, 99);
         if (pick < 5) modulus = '0;
         else if (pick < 10) modulus = W'(1);
         else if (pick < 25) modulus = rand64() >> $urandom_range(32, 62);
         else if (pick < 30) modulus = '1;
         else modulus = rand64();
         configure(exponent, modulus);
         quiet = ($urandom_range(0, 3) == 0);
         count = (bits == W) ? 3 : $urandom_range(10, 40);
         repeat (count) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: begin
                  message = '0;
               end
               1: begin
                  message = '1;
               end
               2: begin
                  message = modulus - 1;
               end
               3: begin
                  message = modulus + W'($urandom_range(0, 2));
               end
               default: begin
                  message = rand64();
               end
            endcase
            send_request(message);
            random_sent++;
         end
      end
      req_ch.valid = 1'b0;

      // Drain, then allow a short tail for any stray response.
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sb.pending.size() != 0) sb.report("requests left without a response");
      if (sb.error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* modular_exponentiation.f */
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_if.sv
hw/rtl/modexp_cell.sv
hw/rtl/modexp_mulmod.sv
hw/rtl/modexp_reduce.sv
hw/rtl/modular_exponentiation.sv
sim/tb.sv
